>>> src/srt_pkg.sv
// Package for the signed radix-to-text unit: widths, character codes,
// register indexes, shared structs and the digit symbol lookup.
// No dependencies.
package srt_pkg;

    localparam int MAX_BASE   = 16;
    localparam int MAX_DIGITS = 32;
    localparam int LEN_W      = 5;   // base_length register width
    localparam int DIGIT_W    = 4;   // one digit value
    localparam int DADDR_W    = 5;   // digit store address
    localparam int COUNT_W    = 6;   // digit count, 0..32
    localparam int SYM_W      = 8;
    localparam int NUM_W      = 32;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    // Register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] base_length;
        logic [63:0]      symbols_low;
        logic [63:0]      symbols_high;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture number, clear counters
        logic check_step;  // advance base check index
        logic div_step;    // one 8-bit division step
        logic div_last;    // final step of a digit: store remainder
        logic emit_start;  // load emit counter from digit count
        logic rd_en;       // read digit store at emit counter - 1
        logic out_minus;   // load minus sign into output register
        logic out_sym;     // load digit symbol, decrement emit counter
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic len_ok;      // base length within 2..MAX_BASE
        logic check_bad;   // current symbol is a sign or repeats later
        logic check_end;   // current symbol is the last one in use
        logic quo_zero;    // quotient after this step is zero
        logic digits_full; // digit store about to be full
        logic negative;
        logic out_free;    // output register can take a character
        logic k_one;       // next character is the final one
    } status_t;

    // Symbol for digit value idx
    function automatic logic [SYM_W-1:0] symbol_at(cfg_t cfg, logic [DIGIT_W-1:0] idx);
        logic [2*64-1:0] all_syms;
        all_syms = {cfg.symbols_high, cfg.symbols_low};
        return all_syms[{idx, 3'b000} +: SYM_W];
    endfunction

endpackage

>>> src/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/srt_regs.sv
// APB-style configuration registers: base length and the sixteen symbols.
// Depends on srt_pkg.
module srt_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srt_pkg::PADDR_W-1:0]   paddr,
    input  logic [srt_pkg::PDATA_W-1:0]   pwdata,
    output logic [srt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output srt_pkg::cfg_t                 cfg
);

    logic [srt_pkg::LEN_W-1:0] base_length_reg;
    logic [63:0]               symbols_low_reg;
    logic [63:0]               symbols_high_reg;
    logic                      wr_xfer;
    logic [1:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg  <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (wr_xfer)
        begin
            case (reg_idx)
                srt_pkg::REG_BASE_LENGTH:  base_length_reg  <= pwdata[srt_pkg::LEN_W-1:0];
                srt_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= pwdata;
                srt_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            srt_pkg::REG_BASE_LENGTH:
                prdata = {{(srt_pkg::PDATA_W-srt_pkg::LEN_W){1'b0}}, base_length_reg};
            srt_pkg::REG_SYMBOLS_LOW:  prdata = symbols_low_reg;
            srt_pkg::REG_SYMBOLS_HIGH: prdata = symbols_high_reg;
            default:                   prdata = '0;
        endcase
    end

    assign cfg.base_length  = base_length_reg;
    assign cfg.symbols_low  = symbols_low_reg;
    assign cfg.symbols_high = symbols_high_reg;

endmodule

>>> src/srt_ctrl.sv
// Controller: sequences base check, digit division, and character emission.
// Depends on srt_pkg.
module srt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  srt_pkg::status_t  status,
    output srt_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_SEND
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.len_ok || status.check_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.check_end)
                begin
                    state_next = ST_DIV;
                    step_next  = 2'd0;
                end
                else
                begin
                    cmd.check_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (step_reg == 2'd3);
                step_next    = step_reg + 2'd1;
                if (cmd.div_last && (status.quo_zero || status.digits_full))
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = status.negative ? ST_SIGN : ST_READ;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.out_minus = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.out_sym = 1'b1;
                    state_next  = status.k_one ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // only one datapath action at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.check_step, cmd.div_step, cmd.rd_en,
                  cmd.out_minus, cmd.out_sym}))
        else $error("srt_ctrl: more than one datapath command");

    // characters only go into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_minus || cmd.out_sym) |-> status.out_free)
        else $error("srt_ctrl: character loaded over a pending transfer");

    // a digit store read is always followed by its send
    a_read_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_SEND))
        else $error("srt_ctrl: read not followed by send");

endmodule

>>> src/srt_dp.sv
// Datapath: sign/magnitude capture, base check, 8-bit-per-cycle divider,
// digit store and output register. Depends on srt_pkg and srt_ram.
module srt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srt_pkg::cfg_t                       cfg,
    input  logic signed [srt_pkg::NUM_W-1:0]    number,
    input  srt_pkg::cmd_t                       cmd,
    output srt_pkg::status_t                    status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [srt_pkg::SYM_W-1:0]           character,
    output logic                                last
);

    logic                            neg_reg;
    logic [srt_pkg::NUM_W-1:0]       dvd_reg, dvd_next;
    logic [srt_pkg::DIGIT_W-1:0]     rem_reg, rem_next;
    logic [srt_pkg::COUNT_W-1:0]     n_reg;
    logic [srt_pkg::COUNT_W-1:0]     k_reg;
    logic [srt_pkg::COUNT_W-1:0]     k_minus;
    logic [srt_pkg::DIGIT_W-1:0]     idx_reg;
    logic                            out_valid_reg;
    logic [srt_pkg::SYM_W-1:0]       character_reg;
    logic                            last_reg;
    logic [srt_pkg::NUM_W-1:0]       mag;
    logic [srt_pkg::SYM_W-1:0]       sym_i;
    logic                            bad;
    logic [srt_pkg::DIGIT_W-1:0]     rd_digit;
    logic [srt_pkg::LEN_W-1:0]       len;

    assign len = cfg.base_length;

    // magnitude; the most negative value maps to 2^31 unsigned
    assign mag = number[srt_pkg::NUM_W-1] ? (32'd0 - $unsigned(number)) : $unsigned(number);

    // base check: symbol idx against sign codes and all later symbols in use
    always_comb
    begin
        sym_i = srt_pkg::symbol_at(cfg, idx_reg);
        bad   = (sym_i == srt_pkg::CHAR_PLUS) || (sym_i == srt_pkg::CHAR_MINUS);
        for (int j = 0; j < srt_pkg::MAX_BASE; j++)
        begin
            if ((5'(j) > {1'b0, idx_reg}) && (5'(j) < len) &&
                (srt_pkg::symbol_at(cfg, 4'(j)) == sym_i))
            begin
                bad = 1'b1;
            end
        end
    end

    // restoring division, eight quotient bits per cycle
    always_comb
    begin
        logic [srt_pkg::LEN_W-1:0]   t;
        logic [srt_pkg::DIGIT_W-1:0] r;
        logic [7:0]                  q;
        r = rem_reg;
        q = '0;
        for (int b = 7; b >= 0; b--)
        begin
            t = {r, dvd_reg[24 + b]};
            if (t >= len)
            begin
                t    = t - len;
                q[b] = 1'b1;
            end
            r = t[srt_pkg::DIGIT_W-1:0];
        end
        rem_next = r;
        dvd_next = {dvd_reg[23:0], q};
    end

    assign k_minus = k_reg - 6'd1;

    // status to controller
    assign status.len_ok      = (len >= 5'd2) && (len <= 5'(srt_pkg::MAX_BASE));
    assign status.check_bad   = bad;
    assign status.check_end   = ({1'b0, idx_reg} == (len - 5'd1));
    assign status.quo_zero    = (dvd_next == '0);
    assign status.digits_full = (n_reg == 6'(srt_pkg::MAX_DIGITS - 1));
    assign status.negative    = neg_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.k_one       = (k_reg == 6'd1);

    // digit store, least significant digit first
    srt_ram #(
        .WIDTH (srt_pkg::DIGIT_W),
        .DEPTH (srt_pkg::MAX_DIGITS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (cmd.div_step && cmd.div_last),
        .wr_addr (n_reg[srt_pkg::DADDR_W-1:0]),
        .wr_data (rem_next),
        .rd_en   (cmd.rd_en),
        .rd_addr (k_minus[srt_pkg::DADDR_W-1:0]),
        .rd_data (rd_digit)
    );

    // counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg   <= '0;
                idx_reg <= '0;
            end
            else if (cmd.check_step)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
            else if (cmd.div_step && cmd.div_last)
            begin
                n_reg <= n_reg + 6'd1;
            end

            if (cmd.emit_start)
            begin
                k_reg <= n_reg + 6'd1;
            end
            else if (cmd.out_sym)
            begin
                k_reg <= k_minus;
            end

            if (cmd.out_minus || cmd.out_sym)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: dividend, remainder, sign, output character
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= number[srt_pkg::NUM_W-1];
            dvd_reg <= mag;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= cmd.div_last ? '0 : rem_next;
        end

        if (cmd.out_minus)
        begin
            character_reg <= srt_pkg::CHAR_MINUS;
            last_reg      <= 1'b0;
        end
        else if (cmd.out_sym)
        begin
            character_reg <= srt_pkg::symbol_at(cfg, rd_digit);
            last_reg      <= (k_reg == 6'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // partial remainder stays below the radix
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < len))
        else $error("srt_dp: partial remainder not below radix");

    // digit store write stays inside the store
    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && cmd.div_last) |-> (n_reg < 6'(srt_pkg::MAX_DIGITS)))
        else $error("srt_dp: digit store write past its end");

    // a digit is only sent while digits remain
    a_k_left: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.out_sym) |-> (k_reg != '0))
        else $error("srt_dp: digit emitted with no digits left");

endmodule

>>> src/signed_radix_to_text_unit.sv
// Top level of the signed radix-to-text unit: register block, controller
// and datapath. Depends on srt_pkg, srt_regs, srt_ctrl, srt_dp.
// Per number: the base check steps through up to base_length symbols in use,
// the divider forms each digit at 8 quotient bits a cycle, then each
// character needs a registered digit store read before it is sent, with a
// minus sign sent first for a negative number.
// Reset clears the controller, counters, output valid and config registers.
module signed_radix_to_text_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srt_pkg::PADDR_W-1:0]         paddr,
    input  logic [srt_pkg::PDATA_W-1:0]         pwdata,
    output logic [srt_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [srt_pkg::NUM_W-1:0]    number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [srt_pkg::SYM_W-1:0]           character,
    output logic                                last
);

    srt_pkg::cfg_t    cfg;
    srt_pkg::cmd_t    cmd;
    srt_pkg::status_t status;

    srt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    srt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .number    (number),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .character (character),
        .last      (last)
    );

endmodule
